// ===== rtl/dmps_pkg.sv =====
// Shared types and constants of the demand matrix priority scheduler.
// Used by dmps_cell and by the top level; depends on nothing else.
package dmps_pkg;

  localparam int NUM_TYPES       = 5;
  localparam int TYPE_W          = 3;
  localparam int MAX_NODES_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam logic [4:0] NODE_COUNT_RST = 5'd16;
  // Settling time of the cell chain: three local stages, one hop per cell, one spare.
  localparam int SCAN_LAT        = NUM_TYPES + 4;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } dmps_kind_t;

  typedef enum logic [1:0] {
    REG_ORDERING    = 2'd0,
    REG_NODE_COUNT  = 2'd1,
    REG_START_INDEX = 2'd2
  } dmps_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_SCAN,
    S_RQ_RD,
    S_RQ_WR,
    S_NONE
  } dmps_state_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  load_type;
    logic [3:0]  load_source;
    logic [3:0]  load_destination;
    logic [15:0] load_count;
  } dmps_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] demand_number;
    logic [4:0]  source_node;
    logic [4:0]  destination_node;
    logic [2:0]  container_type;
    logic [31:0] remaining_total;
  } dmps_out_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic ascending;
  } dmps_ctl_t;

endpackage

// ===== rtl/dmps_cell.sv =====
// One cell of the scheduler chain: count memory and nonzero flags of one container type.
// Searches its own matrix and merges the result into the chain. Depends on dmps_pkg.
module dmps_cell #(
  parameter int MAX_NODES   = dmps_pkg::MAX_NODES_DEF,
  parameter int COUNT_WIDTH = dmps_pkg::COUNT_WIDTH_DEF,
  parameter logic [dmps_pkg::TYPE_W-1:0] CELL_TYPE = '0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dmps_pkg::dmps_ctl_t                ctl,
  input  logic [dmps_pkg::TYPE_W-1:0]        op_type,
  input  logic [$clog2(MAX_NODES)-1:0]       op_src,
  input  logic [$clog2(MAX_NODES)-1:0]       op_dst,
  input  logic [COUNT_WIDTH-1:0]             wdata,
  input  logic [$clog2(MAX_NODES+1)-1:0]     nodes,
  output logic [COUNT_WIDTH-1:0]             rdata,
  input  logic                               chain_in_hit,
  input  logic [dmps_pkg::TYPE_W-1:0]        chain_in_type,
  input  logic [$clog2(MAX_NODES)-1:0]       chain_in_src,
  input  logic [$clog2(MAX_NODES)-1:0]       chain_in_dst,
  output logic                               chain_out_hit,
  output logic [dmps_pkg::TYPE_W-1:0]        chain_out_type,
  output logic [$clog2(MAX_NODES)-1:0]       chain_out_src,
  output logic [$clog2(MAX_NODES)-1:0]       chain_out_dst
);
  import dmps_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int NNP = 2 ** NW;

  logic                   sel;
  logic [2*NW-1:0]        addr;
  logic [COUNT_WIDTH-1:0] mem [NNP*NNP];
  logic [COUNT_WIDTH-1:0] mem_q;
  logic                   flag_q;
  logic                   rd_sel_q;
  logic [NNP-1:0]         flags [NNP];
  logic [NNP-1:0]         dmask;
  logic [NNP-1:0]         row_any_q;
  logic                   row_hit;
  logic [NW-1:0]          row_idx;
  logic                   row_hit_q;
  logic [NW-1:0]          row_q;
  logic [NNP-1:0]         row_bits_q;
  logic                   col_hit;
  logic [NW-1:0]          col_idx;

  assign sel   = (op_type == CELL_TYPE);
  assign addr  = {op_src, op_dst};
  assign rdata = (rd_sel_q && flag_q) ? mem_q : '0;

  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd && sel) begin
      mem_q <= mem[addr];
    end
  end

  // Nonzero flags: a clear flag reads as a zero count.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '{default: '0};
      rd_sel_q <= 1'b0;
      flag_q   <= 1'b0;
    end else begin
      if (ctl.wr && sel) begin
        flags[op_src][op_dst] <= (wdata != '0);
      end
      if (ctl.rd) begin
        rd_sel_q <= sel;
        flag_q   <= flags[op_src][op_dst];
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NNP; d++) begin
      dmask[d] = (NCW'(d) < nodes);
    end
  end

  // Stage A: which rows hold a live entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_any_q <= '0;
    end else begin
      for (int r = 0; r < NNP; r++) begin
        row_any_q[r] <= (NCW'(r) < nodes) && |(flags[r] & dmask);
      end
    end
  end

  // Stage B: first live row.
  always_comb begin
    row_hit = |row_any_q;
    row_idx = '0;
    for (int r = NNP - 1; r >= 0; r--) begin
      if (row_any_q[r]) begin
        row_idx = NW'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_hit_q <= 1'b0;
    end else begin
      row_hit_q <= row_hit;
    end
    row_q      <= row_idx;
    row_bits_q <= flags[row_idx] & dmask;
  end

  // Stage C: first live column, merged with the neighbor's result.
  always_comb begin
    col_hit = row_hit_q && |row_bits_q;
    col_idx = '0;
    for (int d = NNP - 1; d >= 0; d--) begin
      if (row_bits_q[d]) begin
        col_idx = NW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out_hit <= 1'b0;
    end else begin
      chain_out_hit <= chain_in_hit || col_hit;
    end
    if ((ctl.ascending && chain_in_hit) || (!ctl.ascending && !col_hit)) begin
      chain_out_type <= chain_in_type;
      chain_out_src  <= chain_in_src;
      chain_out_dst  <= chain_in_dst;
    end else begin
      chain_out_type <= CELL_TYPE;
      chain_out_src  <= row_q;
      chain_out_dst  <= col_idx;
    end
  end

endmodule

// ===== rtl/demand_matrix_priority_scheduler.sv =====
// Top level of the demand matrix priority scheduler: control, registers, cell chain.
// Instantiates dmps_cell once per container type; depends on dmps_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | dmps_in_t  (load or request)
//   rsp     | out       | rsp_valid/rsp_stall  | dmps_out_t (one per transaction)
//   apb     | in        | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A load passes accept, memory read, then write and result; a load with a field out of range
// goes straight to an empty result. A request that finds a demand passes accept, the settle
// time of the cell chain, then a read and a write of the count memory. A request on an empty
// scan ends with an empty result after the settle time. One transaction is in flight at a time.
// Reset (rst, synchronous) clears the nonzero flags, so the table reads all zero at once.
// A stalled result holds in the output register; the next transaction is accepted behind it.
module demand_matrix_priority_scheduler #(
  parameter int MAX_NODES   = dmps_pkg::MAX_NODES_DEF,
  parameter int COUNT_WIDTH = dmps_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dmps_pkg::dmps_in_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output dmps_pkg::dmps_out_t rsp_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dmps_pkg::*;

  localparam int NW      = $clog2(MAX_NODES);
  localparam int NCW     = $clog2(MAX_NODES + 1);
  localparam int SCAN_CW = $clog2(SCAN_LAT + 1);

  // Configuration registers.
  logic        ordering_q;
  logic [4:0]  node_count_q;
  logic [31:0] start_index_q;
  logic        cfg_wr;
  dmps_reg_t   reg_sel;

  // Scheduler state.
  dmps_state_t         state, state_next;
  dmps_in_t            item_q;
  logic [31:0]         next_index;
  logic [31:0]         pending_total;
  logic [SCAN_CW-1:0]  scan_cnt;
  logic [TYPE_W-1:0]   op_type;
  logic [NW-1:0]       op_src;
  logic [NW-1:0]       op_dst;
  logic [NCW-1:0]      nodes_eff;
  logic                accept;
  logic                load_ok;
  logic                out_free;
  logic                emit;
  logic                use_load_data;
  dmps_ctl_t           ctl;
  dmps_out_t           rsp_data_next;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] rd_old;
  logic [COUNT_WIDTH-1:0] cell_rdata [NUM_TYPES];

  // Chain links: link 0 feeds the first cell, the last link is the result.
  logic              ch_hit  [NUM_TYPES+1];
  logic [TYPE_W-1:0] ch_type [NUM_TYPES+1];
  logic [NW-1:0]     ch_src  [NUM_TYPES+1];
  logic [NW-1:0]     ch_dst  [NUM_TYPES+1];

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = dmps_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_ORDERING:    prdata = {31'd0, ordering_q};
      REG_NODE_COUNT:  prdata = {27'd0, node_count_q};
      REG_START_INDEX: prdata = start_index_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ordering_q    <= 1'b0;
      node_count_q  <= NODE_COUNT_RST;
      start_index_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ORDERING:    ordering_q    <= pwdata[0];
        REG_NODE_COUNT:  node_count_q  <= pwdata[4:0];
        REG_START_INDEX: start_index_q <= pwdata;
        default:         ;
      endcase
    end
  end

  // Saturate the node count to the matrix size.
  assign nodes_eff = (32'(node_count_q) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_q);

  // ---------------- handshake helpers ----------------
  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign load_ok  = (32'(req_data.load_type) < NUM_TYPES) &&
                    (32'(req_data.load_source) < MAX_NODES) &&
                    (32'(req_data.load_destination) < MAX_NODES);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_data.kind == KIND_REQUEST) begin
            state_next = S_SCAN;
          end else if (load_ok) begin
            state_next = S_LD_RD;
          end else begin
            state_next = S_NONE;
          end
        end
      end
      S_LD_RD: state_next = S_LD_WR;
      S_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = ch_hit[NUM_TYPES] ? S_RQ_RD : S_NONE;
        end
      end
      S_RQ_RD: state_next = S_RQ_WR;
      S_LD_WR, S_RQ_WR, S_NONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    req_stall     = 1'b1;
    ctl.rd        = 1'b0;
    ctl.wr        = 1'b0;
    ctl.ascending = ordering_q;
    emit          = 1'b0;
    use_load_data = 1'b0;
    unique case (state)
      S_IDLE:  req_stall = 1'b0;
      S_LD_RD, S_RQ_RD: ctl.rd = 1'b1;
      S_LD_WR: begin
        ctl.wr        = out_free;
        emit          = out_free;
        use_load_data = 1'b1;
      end
      S_RQ_WR: begin
        ctl.wr = out_free;
        emit   = out_free;
      end
      S_NONE:  emit = out_free;
      S_SCAN:  ;
      default: ;
    endcase
  end

  always_comb begin
    rd_old = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      rd_old = rd_old | cell_rdata[t];
    end
  end

  // Load writes the new count; an emitted demand drops its count by one.
  assign wdata = use_load_data ? COUNT_WIDTH'(item_q.load_count) : rd_old - 1'b1;

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_index    <= '0;
      pending_total <= '0;
      rsp_valid     <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        scan_cnt <= SCAN_CW'(SCAN_LAT);
      end else if (state == S_SCAN && scan_cnt != '0) begin
        scan_cnt <= scan_cnt - 1'b1;
      end
      if (cfg_wr && reg_sel == REG_START_INDEX) begin
        next_index <= pwdata;
      end else if (emit && state == S_RQ_WR) begin
        next_index <= next_index + 1'b1;
      end
      if (emit && state == S_LD_WR) begin
        pending_total <= pending_total - 32'(rd_old) + 32'(wdata);
      end else if (emit && state == S_RQ_WR) begin
        pending_total <= pending_total - 1'b1;
      end
    end
  end

  // Hold the transaction and the table entry it works on.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q  <= req_data;
      op_type <= req_data.load_type;
      op_src  <= NW'(req_data.load_source);
      op_dst  <= NW'(req_data.load_destination);
    end else if (state == S_SCAN && scan_cnt == '0) begin
      op_type <= ch_type[NUM_TYPES];
      op_src  <= ch_src[NUM_TYPES];
      op_dst  <= ch_dst[NUM_TYPES];
    end
  end

  // Result register.
  always_comb begin
    rsp_data_next = '0;
    unique case (state)
      S_LD_WR: rsp_data_next.remaining_total = pending_total - 32'(rd_old) + 32'(wdata);
      S_RQ_WR: begin
        rsp_data_next.found            = 1'b1;
        rsp_data_next.demand_number    = next_index;
        rsp_data_next.source_node      = 5'((NW+1)'(op_src) + 1'b1);
        rsp_data_next.destination_node = 5'((NW+1)'(op_dst) + 1'b1);
        rsp_data_next.container_type   = op_type;
        rsp_data_next.remaining_total  = pending_total - 1'b1;
      end
      default: rsp_data_next.remaining_total = pending_total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_data <= rsp_data_next;
    end
  end

  // ---------------- cell chain ----------------
  assign ch_hit[0]  = 1'b0;
  assign ch_type[0] = '0;
  assign ch_src[0]  = '0;
  assign ch_dst[0]  = '0;

  for (genvar t = 0; t < NUM_TYPES; t++) begin : g_cell
    dmps_cell #(
      .MAX_NODES   (MAX_NODES),
      .COUNT_WIDTH (COUNT_WIDTH),
      .CELL_TYPE   (TYPE_W'(t))
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .op_type        (op_type),
      .op_src         (op_src),
      .op_dst         (op_dst),
      .wdata          (wdata),
      .nodes          (nodes_eff),
      .rdata          (cell_rdata[t]),
      .chain_in_hit   (ch_hit[t]),
      .chain_in_type  (ch_type[t]),
      .chain_in_src   (ch_src[t]),
      .chain_in_dst   (ch_dst[t]),
      .chain_out_hit  (ch_hit[t+1]),
      .chain_out_type (ch_type[t+1]),
      .chain_out_src  (ch_src[t+1]),
      .chain_out_dst  (ch_dst[t+1])
    );
  end

endmodule
